// ===== rtl/core/phrn_pkg.sv =====
// ----------------------------------------------------------------------------
// phrn_pkg
// shared types and constants of the per-head rms normalization block
// ----------------------------------------------------------------------------
`default_nettype none
package phrn_pkg;

   localparam int MAX_HEAD_DIM_DEF = 64;
   localparam int LEN_W            = 7;
   localparam int EPS_W            = 20;
   localparam int CSR_DATA_W       = 20;
   localparam int SUM_W            = 38;
   localparam int M_W              = 32;
   localparam int Q_W              = 61;
   localparam int INV_W            = 31;

   localparam logic CSR_HEAD_LEN = 1'b0;
   localparam logic CSR_EPSILON  = 1'b1;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] gain;
      logic               vector_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normed;
      logic               head_last;
      logic               vector_last;
      logic               saturated;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mean_start;
      logic div_start;
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic emit_rd;
      logic emit_mul;
      logic emit_out;
      logic head_clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic head_done;
      logic last_rd;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/phrn_datapath.sv =====
// ----------------------------------------------------------------------------
// phrn_datapath
// buffers, square sum, serial divider and square root, output multiplier
// ----------------------------------------------------------------------------
`default_nettype none
module phrn_datapath #(
   parameter int MAX_HEAD_DIM = phrn_pkg::MAX_HEAD_DIM_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire phrn_pkg::req_type               req_data,
   input  wire logic [phrn_pkg::LEN_W-1:0]      head_len,
   input  wire logic [phrn_pkg::EPS_W-1:0]      epsilon,
   input  wire phrn_pkg::cmd_type               cmd,
   output phrn_pkg::status_type                 status,
   output phrn_pkg::rsp_type                    rsp_data
);
   localparam int IDX_W = $clog2(MAX_HEAD_DIM);
   localparam int CNT_W = $clog2(MAX_HEAD_DIM + 1);

   logic [15:0] sample_mem [MAX_HEAD_DIM];
   logic [15:0] gain_mem   [MAX_HEAD_DIM];

   logic [phrn_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       endp_ff, endp_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           eff_len;
   logic [IDX_W-1:0]           wr_idx;
   logic signed [31:0]         sq;

   // effective head length
   always_comb begin
      if (head_len == '0) eff_len = CNT_W'(1);
      else if (32'(head_len) > MAX_HEAD_DIM) eff_len = CNT_W'(MAX_HEAD_DIM);
      else eff_len = CNT_W'(head_len);
   end

   assign wr_idx = (32'(count_ff) >= MAX_HEAD_DIM) ? IDX_W'(MAX_HEAD_DIM - 1)
                                                   : count_ff[IDX_W-1:0];
   assign sq = req_data.sample * req_data.sample;

   // element load and accumulation
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_mem[wr_idx] <= req_data.sample;
         gain_mem[wr_idx]   <= req_data.gain;
      end
   end

   // a head ends only on a load that brings the count to or past the length
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      endp_in  = endp_ff;
      done_in  = done_ff;
      if (cmd.head_clear) begin
         sum_in = '0; count_in = '0; endp_in = 1'b0; done_in = 1'b0;
      end else if (cmd.load) begin
         sum_in   = sum_ff + phrn_pkg::SUM_W'(unsigned'(sq));
         count_in = CNT_W'(wr_idx) + CNT_W'(1);
         endp_in  = endp_ff | req_data.vector_end;
         done_in  = (count_in >= eff_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0; count_ff <= '0; endp_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in; count_ff <= count_in; endp_ff <= endp_in;
         done_ff <= done_in;
      end
   end

   assign status.head_done = done_ff;

   // shared restoring divider: first sum/n, then 2^60/m, one bit a cycle
   logic [phrn_pkg::Q_W-1:0]   num_ff, num_in;
   logic [phrn_pkg::M_W:0]     rem_ff, rem_in;
   logic [phrn_pkg::M_W-1:0]   den_ff, den_in;
   logic [phrn_pkg::M_W+1:0]   trial;
   logic [phrn_pkg::M_W:0]     rem_sh;
   logic [phrn_pkg::M_W-1:0]   m_val;

   assign rem_sh = {rem_ff[phrn_pkg::M_W-1:0], num_ff[phrn_pkg::Q_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b0, den_ff};
   // quotient low part of first division is the mean (fits 32 bits)
   always_comb begin
      m_val = num_ff[phrn_pkg::M_W-1:0] + phrn_pkg::M_W'(epsilon);
      if (m_val == '0) m_val = phrn_pkg::M_W'(1);
   end

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      if (cmd.mean_start) begin
         num_in = phrn_pkg::Q_W'(sum_ff);
         rem_in = '0;
         den_in = phrn_pkg::M_W'(count_ff);
      end else if (cmd.div_start) begin
         num_in = phrn_pkg::Q_W'(1) << 60;
         rem_in = '0;
         den_in = m_val;
      end else if (cmd.div_step) begin
         if (!trial[phrn_pkg::M_W+1]) begin
            rem_in = trial[phrn_pkg::M_W:0];
            num_in = {num_ff[phrn_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            num_in = {num_ff[phrn_pkg::Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   // digit-by-digit square root, two radicand bits a cycle
   logic [61:0]                  rad_ff, rad_in;
   logic [phrn_pkg::INV_W+1:0]   srem_ff, srem_in;
   logic [phrn_pkg::INV_W-1:0]   root_ff, root_in;
   logic [phrn_pkg::INV_W+1:0]   s_sh, s_try;

   assign s_sh  = {srem_ff[phrn_pkg::INV_W-1:0], rad_ff[61:60]};
   assign s_try = s_sh - {root_ff, 2'b01};

   always_comb begin
      rad_in = rad_ff; srem_in = srem_ff; root_in = root_ff;
      if (cmd.sqrt_start) begin
         rad_in  = {1'b0, num_ff};
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in = {rad_ff[59:0], 2'b00};
         if (!s_try[phrn_pkg::INV_W+1]) begin
            srem_in = s_try;
            root_in = {root_ff[phrn_pkg::INV_W-2:0], 1'b1};
         end else begin
            srem_in = s_sh;
            root_in = {root_ff[phrn_pkg::INV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in; srem_ff <= srem_in; root_ff <= root_in;
   end

   // emit: read, s*g, then |sg|*inv, then round and saturate
   logic [CNT_W-1:0]   rd_ff, rd_in;
   logic [15:0]        rs_ff, rg_ff;
   logic               rl_ff, ml_ff;
   logic signed [31:0] sg;
   logic [30:0]        mag_ff;
   logic               neg_ff;
   logic [61:0]        prod;
   logic [30:0]        r;
   phrn_pkg::rsp_type  out_ff, out_in;

   assign rd_in = cmd.sqrt_start ? '0 : (cmd.emit_rd ? rd_ff + CNT_W'(1) : rd_ff);
   assign status.last_rd = (rd_ff + CNT_W'(1) == count_ff);

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (cmd.emit_rd) begin
         rs_ff <= sample_mem[rd_ff[IDX_W-1:0]];
         rg_ff <= gain_mem[rd_ff[IDX_W-1:0]];
         rl_ff <= status.last_rd;
      end
   end

   assign sg = signed'(rs_ff) * signed'(rg_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit_mul) begin
         neg_ff <= sg[31];
         mag_ff <= sg[31] ? 31'(-sg) : sg[30:0];
         ml_ff  <= rl_ff;
      end
   end

   assign prod = 62'(mag_ff) * 62'(root_ff);
   assign r    = 31'((prod + (62'(1) << 31)) >> 32);

   always_comb begin
      out_in = out_ff;
      out_in.head_last   = ml_ff;
      out_in.vector_last = ml_ff & endp_ff;
      if (neg_ff) begin
         out_in.saturated = (r > 31'd32768);
         out_in.normed    = out_in.saturated ? 16'sh8000 : 16'(-r[15:0]);
      end else begin
         out_in.saturated = (r > 31'd32767);
         out_in.normed    = out_in.saturated ? 16'sh7fff : r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_out) out_ff <= out_in;
   end

   assign rsp_data = out_ff;
endmodule
`default_nettype wire

// ===== rtl/core/phrn_ctrl.sv =====
// ----------------------------------------------------------------------------
// phrn_ctrl
// sequencer for load, reciprocal square root and emission
// ----------------------------------------------------------------------------
`default_nettype none
module phrn_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire phrn_pkg::status_type status,
   output phrn_pkg::cmd_type     cmd
);
   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_MEAN = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;
   localparam logic [2:0] S_CHK  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;

   assign req_ready = (state_ff == S_LOAD) && !status.head_done;
   assign rsp_valid = valid_ff;

   // state sequencing
   always_comb begin
      state_in = state_ff; step_in = step_ff; valid_in = valid_ff; last_in = last_ff;
      cmd = '0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load = req_valid && req_ready;
            if (status.head_done) begin
               cmd.mean_start = 1'b1; state_in = S_MEAN; step_in = '0;
            end
         end
         S_MEAN: begin
            cmd.div_step = 1'b1; step_in = step_ff + 6'd1;
            if (step_ff == 6'd60) begin state_in = S_DIV; end
         end
         S_DIV: begin
            if (step_ff == 6'd61) begin
               cmd.div_start = 1'b1; step_in = '0;
            end else begin
               cmd.div_step = 1'b1; step_in = step_ff + 6'd1;
               // last quotient bit lands this cycle, sqrt setup follows
               if (step_ff == 6'd60) begin
                  state_in = S_SQRT; step_in = 6'd63;
               end
            end
         end
         S_SQRT: begin
            if (step_ff == 6'd63) begin
               cmd.sqrt_start = 1'b1; step_in = '0;
            end else if (step_ff == 6'd30) begin
               cmd.sqrt_step = 1'b1; state_in = S_RD;
            end else begin
               cmd.sqrt_step = 1'b1; step_in = step_ff + 6'd1;
            end
         end
         S_RD: begin
            cmd.emit_rd = 1'b1; last_in = status.last_rd; state_in = S_MUL;
         end
         S_MUL: begin
            cmd.emit_mul = 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.emit_out = 1'b1; valid_in = 1'b1;
               if (last_ff) begin
                  cmd.head_clear = 1'b1; state_in = S_LOAD;
               end else state_in = S_RD;
            end
         end
         S_CHK: state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; step_ff <= '0; valid_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; valid_ff <= valid_in;
         last_ff <= last_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/per_head_rms_norm.sv =====
// ----------------------------------------------------------------------------
// per_head_rms_norm
// per-head rms normalization with gain, fixed point
// ----------------------------------------------------------------------------
// channel   dir   handshake            payload
// req       in    req_valid/req_ready  sample, gain, vector_end
// rsp       out   rsp_valid/rsp_ready  normed, head_last, vector_last, saturated
// csr       in    csr_write_enable     csr_index, csr_write_data
//
// each accepted element is stored and summed; the head's last element starts a
// 61-step mean division, a 61-step reciprocal division and a 31-step
// square root, each behind a setup step, then each result passes through
// buffer read, multiply and round.
// synchronous reset, no clearing pass.
// a stalled rsp holds the emit sequence; req is not taken while emitting.
// ----------------------------------------------------------------------------
`default_nettype none
module per_head_rms_norm #(
   parameter int MAX_HEAD_DIM = phrn_pkg::MAX_HEAD_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire phrn_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output phrn_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_write_enable,
   input  wire logic                             csr_index,
   input  wire logic [phrn_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   logic [phrn_pkg::LEN_W-1:0] head_len_ff;
   logic [phrn_pkg::EPS_W-1:0] epsilon_ff;
   phrn_pkg::cmd_type    cmd;
   phrn_pkg::status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_len_ff <= phrn_pkg::LEN_W'(64);
         epsilon_ff  <= phrn_pkg::EPS_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            phrn_pkg::CSR_HEAD_LEN: head_len_ff <= csr_write_data[phrn_pkg::LEN_W-1:0];
            phrn_pkg::CSR_EPSILON:  epsilon_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   phrn_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   phrn_datapath #(.MAX_HEAD_DIM(MAX_HEAD_DIM)) u_dp (
      .clock, .reset, .req_data, .head_len(head_len_ff), .epsilon(epsilon_ff),
      .cmd, .status, .rsp_data
   );
endmodule
`default_nettype wire

// ===== rtl/core/phrn_checker.sv =====
// ----------------------------------------------------------------------------
// phrn_assert
// port-level checks of the per-head rms normalization block
// ----------------------------------------------------------------------------
`default_nettype none
module phrn_assert (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire phrn_pkg::rsp_type rsp_data
);
   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed under stall");
   // vector end only on a head's last item
   a_vec_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.vector_last || rsp_data.head_last)
      else $error("vector_last without head_last");
   // no input taken while a result other than a head's last is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.head_last |-> !req_ready)
      else $error("input taken mid-emit");
   // after reset nothing is shown
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind per_head_rms_norm phrn_assert u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire

// ===== sim/phrn_checker.sv =====
// ----------------------------------------------------------------------------
// phrn_checker
// watches the req, rsp and csr ports of per_head_rms_norm, predicts every
// normalized result from the accepted items and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module phrn_checker
   import phrn_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                          fail_count,
   output int                          pending_count,
   output int                          result_count
);

   localparam int MAX_DIM = MAX_HEAD_DIM_DEF;

   // mirrored registers and head state
   logic [LEN_W-1:0]   head_len_q;
   logic [EPS_W-1:0]   epsilon_q;
   logic [15:0]        sample_buf [MAX_DIM];
   logic [15:0]        gain_buf [MAX_DIM];
   longint unsigned    square_sum;
   int                 element_count;
   logic               end_pending;
   rsp_type            expected_q [$];

   assign pending_count = expected_q.size();

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // load one element; at the head's end queue every normalized result
   task automatic predict_head(input req_type item);
      int              len;
      int              n;
      longint signed   x;
      longint signed   sg;
      longint unsigned mean_sq;
      longint unsigned inv;
      longint unsigned mag;
      longint unsigned r;
      rsp_type         res;
      len = (head_len_q == 0) ? 1 : (head_len_q > MAX_DIM) ? MAX_DIM : int'(head_len_q);
      if (element_count >= MAX_DIM) element_count = MAX_DIM - 1;
      sample_buf[element_count] = item.sample;
      gain_buf[element_count]   = item.gain;
      x = longint'(item.sample);
      square_sum = square_sum + longint'(x * x);
      if (item.vector_end) end_pending = 1'b1;
      element_count++;
      if (element_count < len) return;

      n = element_count;
      mean_sq = square_sum / n + epsilon_q;
      if (mean_sq == 0) mean_sq = 1;
      inv = int_sqrt((64'd1 << 60) / mean_sq);
      for (int k = 0; k < n; k++) begin
         sg  = longint'($signed(sample_buf[k])) * longint'($signed(gain_buf[k]));
         mag = (sg < 0) ? longint'(-sg) : longint'(sg);
         r   = (mag * inv + (64'd1 << 31)) >> 32;
         res.saturated = 1'b0;
         if (sg < 0) begin
            if (r > 32768) begin
               r = 32768;
               res.saturated = 1'b1;
            end
            res.normed = 16'(-longint'(r));
         end else begin
            if (r > 32767) begin
               r = 32767;
               res.saturated = 1'b1;
            end
            res.normed = 16'(r);
         end
         res.head_last   = (k == n - 1);
         res.vector_last = (k == n - 1) ? end_pending : 1'b0;
         expected_q.push_back(res);
      end
      square_sum    = 0;
      element_count = 0;
      end_pending   = 1'b0;
   endtask

   task automatic report(input string field, input int got, input int want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count   = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_len_q    <= 7'd64;
         epsilon_q     <= 20'd1;
         square_sum    = 0;
         element_count = 0;
         end_pending   = 1'b0;
         expected_q.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            if (csr_index == CSR_HEAD_LEN) head_len_q <= csr_write_data[LEN_W-1:0];
            else                           epsilon_q  <= csr_write_data[EPS_W-1:0];
         end
         // accepted input item
         if (req_valid && req_ready) predict_head(req_data);
         // accepted result
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result normed", rsp_data.normed, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.normed !== want.normed)
                  report("normed", rsp_data.normed, want.normed);
               if (rsp_data.head_last !== want.head_last)
                  report("head_last", rsp_data.head_last, want.head_last);
               if (rsp_data.vector_last !== want.vector_last)
                  report("vector_last", rsp_data.vector_last, want.vector_last);
               if (rsp_data.saturated !== want.saturated)
                  report("saturated", rsp_data.saturated, want.saturated);
            end
            result_count++;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sim/per_head_rms_norm_tb.sv =====
// ----------------------------------------------------------------------------
// per_head_rms_norm_tb
// drives per_head_rms_norm with directed and random heads over several
// head lengths and epsilon values, with random gaps on both channels and
// one long result stall; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module per_head_rms_norm_tb;
   import phrn_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_index = CSR_HEAD_LEN;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int  fail_count;
   int  pending_count;
   int  result_count;
   int  cycle_count = 0;
   int  items_sent = 0;
   int  settings_used = 0;
   bit  no_gaps = 1'b0;
   bit  long_hold = 1'b0;

   always #5 clock = ~clock;

   per_head_rms_norm u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   phrn_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_write_enable, .csr_index, .csr_write_data,
      .fail_count, .pending_count, .result_count
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // offer one item; valid stays high into the next item when there is no gap
   task automatic send_element(input logic [15:0] s, input logic [15:0] g, input logic ve);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: s, gain: g, vector_end: ve};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_reg(input logic idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait until nothing is outstanding and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input int len, input int eps);
      write_reg(CSR_HEAD_LEN, len);
      write_reg(CSR_EPSILON, eps);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'($urandom_range(0, 63)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // result side: random stalls, and one long hold-off on request
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int lens [8]  = '{3, 64, 1, 8, 127, 13, 2, 5};
      int heads [8] = '{2, 1, 4, 2, 1, 2, 4, 4};
      int len_eff;
      logic ve;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero mean square with zero epsilon
      set_mode(4, 0);
      repeat (4) send_element(16'h0000, 16'($urandom), 1'b0);
      drain();
      // field extremes, epsilon at maximum
      set_mode(4, 1048575);
      send_element(16'h8000, 16'h8000, 1'b0);
      send_element(16'h7fff, 16'h7fff, 1'b0);
      send_element(16'h8000, 16'h7fff, 1'b0);
      send_element(16'h0001, 16'hffff, 1'b0);
      drain();
      // early vector end latched to the head's last result
      set_mode(4, 1);
      send_element(16'h0400, 16'h1000, 1'b0);
      send_element(16'hfc00, 16'h1000, 1'b1);
      send_element(16'h0200, 16'hf000, 1'b0);
      send_element(16'h0000, 16'h1000, 1'b0);
      drain();
      // zero head length acts as one
      set_mode(0, 1);
      send_element(16'h1234, 16'h0800, 1'b1);
      send_element(16'hedcb, 16'h8000, 1'b0);
      drain();
      // length lowered while a head is partly loaded
      set_mode(5, 1);
      repeat (3) send_element(pick_value(), pick_value(), 1'b0);
      drain();
      write_reg(CSR_HEAD_LEN, 2);
      send_element(pick_value(), pick_value(), 1'b1);
      drain();

      // random heads over several settings, every other one without gaps
      for (int p = 0; p < 8; p++) begin
         set_mode(lens[p], (p == 3) ? 0 : $urandom_range(0, 1048575));
         no_gaps = p[0];
         len_eff = (lens[p] > 64) ? 64 : lens[p];
         if (p == 5) long_hold = 1'b1;
         for (int h = 0; h < heads[p]; h++) begin
            for (int e = 0; e < len_eff; e++) begin
               ve = ((h == heads[p] - 1) && (e == len_eff - 1)) ||
                    ($urandom_range(0, 15) == 0);
               send_element(pick_value(), pick_value(), ve);
            end
         end
         drain();
         no_gaps = 1'b0;
      end

      $display("sent %0d items under %0d register settings, %0d results checked",
               items_sent, settings_used, result_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/phrn_pkg.sv
rtl/core/phrn_datapath.sv
rtl/core/phrn_ctrl.sv
rtl/core/per_head_rms_norm.sv
rtl/core/phrn_checker.sv
sim/phrn_checker.sv
sim/per_head_rms_norm_tb.sv
